### rtl/separator_field_splitter_unit_assert.svh
// Assertion macros used by the separator field splitter top level.
`ifndef SEPARATOR_FIELD_SPLITTER_UNIT_ASSERT_SVH
`define SEPARATOR_FIELD_SPLITTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk and held off while arst_n is low.
`define SFS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("separator field splitter: same-cycle check failed");

// Next-cycle implication, checked on clk and held off while arst_n is low.
`define SFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("separator field splitter: next-cycle check failed");

`endif

### rtl/sfs_pkg.sv
// Types and constants of the separator field splitter.
package sfs_pkg;

	localparam int FIELD_W    = 11;
	localparam int SEP_LANES  = 8;
	localparam int SEP_BYTES_W = 8 * SEP_LANES;
	localparam int SEP_LEN_W  = 4;
	localparam int CFG_IDX_W  = 2;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam logic [SEP_BYTES_W-1:0] SPACE_SEP = 64'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEP_BYTES = 2'd0,
		CFG_SEP_LEN   = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] field_index;
		logic [FIELD_W-1:0] field_offset;
		logic [FIELD_W-1:0] field_length;
		logic               last_field;
		logic               record_too_long;
	} field_desc_t;

	typedef struct packed {
		logic [SEP_BYTES_W-1:0] bytes;
		logic [SEP_LEN_W-1:0]   len;
	} sep_cfg_t;

endpackage

### rtl/sfs_match.sv
// Windowed masked compare of the newest bytes against the separator.
module sfs_match #(
	parameter int MAX_SEPARATOR = 8
) (
	input  logic [8*MAX_SEPARATOR-1:0] window,
	input  sfs_pkg::sep_cfg_t          sep,
	output logic                       hit
);

	logic [7:0] win_b [sfs_pkg::SEP_LANES];
	logic [7:0] sep_b [sfs_pkg::SEP_LANES];
	logic [sfs_pkg::SEP_LANES-1:0] lane_ok;

	genvar i;
	generate
		for (i = 0; i < sfs_pkg::SEP_LANES; i++) begin : g_lane
			logic [2:0] age;

			if (i < MAX_SEPARATOR) begin : g_win
				assign win_b[i] = window[8*i +: 8];
			end else begin : g_pad
				assign win_b[i] = 8'h00;
			end
			assign sep_b[i] = sep.bytes[8*i +: 8];

			// separator byte i sits at age len-1-i in the window
			assign age = 3'(sep.len - sfs_pkg::SEP_LEN_W'(1) - sfs_pkg::SEP_LEN_W'(i));
			assign lane_ok[i] = (sfs_pkg::SEP_LEN_W'(i) >= sep.len) || (win_b[age] == sep_b[i]);
		end
	endgenerate

	assign hit = &lane_ok;

endmodule

### rtl/sfs_track.sv
// Record state and field descriptor generation, one item per cycle while advance is high.
module sfs_track #(
	parameter int MAX_RECORD    = 1024,
	parameter int MAX_SEPARATOR = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  sfs_pkg::in_item_t    item,
	input  sfs_pkg::sep_cfg_t    sep,
	output logic                 res_valid,
	output sfs_pkg::field_desc_t res
);

	localparam int POS_W = $clog2(MAX_RECORD + 1);
	localparam int WIN_W = 8 * MAX_SEPARATOR;

	logic [WIN_W-1:0] window_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] start_q;
	logic [POS_W-1:0] count_q;
	logic [POS_W-1:0] fieldno_q;
	logic             ovf_q;

	logic [WIN_W+7:0] win_shift;
	logic [WIN_W-1:0] win_next;
	logic [POS_W-1:0] pos_inc;
	logic [POS_W-1:0] count_inc;
	logic             full;
	logic             hit;
	logic             is_sep;
	logic             is_end;

	assign win_shift = {window_q, item.data_byte};
	assign win_next  = win_shift[WIN_W-1:0];

	sfs_match #(
		.MAX_SEPARATOR(MAX_SEPARATOR)
	) u_match (
		.window(win_next),
		.sep   (sep),
		.hit   (hit)
	);

	always_comb begin
		is_end    = (item.command == sfs_pkg::CMD_END);
		full      = (pos_q >= POS_W'(MAX_RECORD));
		pos_inc   = pos_q + POS_W'(1);
		count_inc = count_q + POS_W'(1);
		is_sep    = (count_inc >= POS_W'(sep.len)) && hit;
		res_valid = advance && (is_end || (!full && is_sep));

		if (is_end && ovf_q) begin
			res.field_index     = '0;
			res.field_offset    = '0;
			res.field_length    = '0;
			res.last_field      = 1'b1;
			res.record_too_long = 1'b1;
		end else if (is_end) begin
			res.field_index     = sfs_pkg::FIELD_W'(fieldno_q);
			res.field_offset    = sfs_pkg::FIELD_W'(start_q);
			res.field_length    = sfs_pkg::FIELD_W'(count_q);
			res.last_field      = 1'b1;
			res.record_too_long = 1'b0;
		end else begin
			res.field_index     = sfs_pkg::FIELD_W'(fieldno_q);
			res.field_offset    = sfs_pkg::FIELD_W'(start_q);
			res.field_length    = sfs_pkg::FIELD_W'(count_inc - POS_W'(sep.len));
			res.last_field      = 1'b0;
			res.record_too_long = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= '0;
			pos_q     <= '0;
			start_q   <= '0;
			count_q   <= '0;
			fieldno_q <= '0;
			ovf_q     <= 1'b0;
		end else if (advance) begin
			if (is_end) begin
				window_q  <= '0;
				pos_q     <= '0;
				start_q   <= '0;
				count_q   <= '0;
				fieldno_q <= '0;
				ovf_q     <= 1'b0;
			end else if (full) begin
				ovf_q <= 1'b1;
			end else begin
				window_q <= win_next;
				pos_q    <= pos_inc;
				if (is_sep) begin
					fieldno_q <= fieldno_q + POS_W'(1);
					start_q   <= pos_inc;
					count_q   <= '0;
				end else begin
					count_q <= count_inc;
				end
			end
		end
	end

endmodule

### rtl/separator_field_splitter_unit.sv
// A request is held in the input register, then its descriptor in the result register.
// Throughput: one request per cycle; the only limit is the result register being held
// by out_stall, which then holds the input register and raises in_stall.
// Reset (arst_n low, asynchronous): record state clears, separator returns to one space
// with length one, both stages empty. No clearing pass; requests are taken right away.
`include "separator_field_splitter_unit_assert.svh"

module separator_field_splitter_unit #(
	parameter int MAX_RECORD    = 1024,
	parameter int MAX_SEPARATOR = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// record byte / end-of-record requests
	input  logic                                in_valid,
	output logic                                in_stall,
	input  sfs_pkg::in_item_t                   in_data,
	// field descriptors
	output logic                                out_valid,
	input  logic                                out_stall,
	output sfs_pkg::field_desc_t                out_data,
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sfs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sfs_pkg::SEP_BYTES_W-1:0]     cfg_data
);

	// Input register stage.
	logic              valid_s1;
	sfs_pkg::in_item_t item_s1;

	// Result register stage.
	logic                 out_valid_q;
	sfs_pkg::field_desc_t out_data_q;

	// Separator configuration.
	sfs_pkg::sep_cfg_t sep_q;

	logic                 advance;
	logic                 res_valid;
	sfs_pkg::field_desc_t res;

	// Advance the input stage whenever the result register is free or drains this cycle.
	// An item that yields no descriptor still needs that slot: keeping the rule simple
	// costs nothing in rate since the slot frees every cycle out_stall is low.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Hold the input register while stalled, otherwise take the next request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			item_s1 <= in_data;
		end
	end

	// Load a new descriptor when the stage advances, drop the old one once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_data_q <= res;
		end
	end

	// Register writes; a length outside one to MAX_SEPARATOR keeps the old value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q.bytes <= sfs_pkg::SPACE_SEP;
			sep_q.len   <= sfs_pkg::SEP_LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (sfs_pkg::cfg_reg_t'(cfg_index))
				sfs_pkg::CFG_SEP_BYTES: begin
					sep_q.bytes <= cfg_data;
				end
				sfs_pkg::CFG_SEP_LEN: begin
					if (cfg_data[sfs_pkg::SEP_LEN_W-1:0] >= sfs_pkg::SEP_LEN_W'(1) &&
					    cfg_data[sfs_pkg::SEP_LEN_W-1:0] <= sfs_pkg::SEP_LEN_W'(MAX_SEPARATOR)) begin
						sep_q.len <= cfg_data[sfs_pkg::SEP_LEN_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Field tracking and separator match for the item in the input register.
	sfs_track #(
		.MAX_RECORD   (MAX_RECORD),
		.MAX_SEPARATOR(MAX_SEPARATOR)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.sep      (sep_q),
		.res_valid(res_valid),
		.res      (res)
	);

	// A rejected record reports only the final, zeroed descriptor.
	`SFS_ASSERT_NOW(a_reject_shape, out_valid_q && out_data_q.record_too_long,
		out_data_q.last_field && out_data_q.field_index == '0 &&
		out_data_q.field_offset == '0 && out_data_q.field_length == '0)
	// A held result with a waiting item must back-pressure the input.
	`SFS_ASSERT_NOW(a_backpressure, out_valid_q && out_stall && valid_s1, in_stall)
	// A descriptor produced while the output drains is presented on the next cycle.
	`SFS_ASSERT_NEXT(a_result_loads, advance && res_valid, out_valid_q)

endmodule

### sim/tb.sv
// Self-checking testbench for the separator field splitter: random records, predicted descriptors.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfs_pkg::*;

	localparam int REC_LIMIT = 1024;
	localparam int SEP_MAX   = 8;

	// Register indexes that the block does not decode; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	in_item_t               in_data   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	field_desc_t            out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [SEP_BYTES_W-1:0] cfg_data  = '0;

	// Requests waiting for the driver, and descriptors waiting for the block to produce them.
	in_item_t    byte_requests[$];
	field_desc_t descs_due[$];
	int          queued_items   = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          mismatch_count = 0;

	// Our own copy of the splitter: separator setting plus record state.
	logic [SEP_BYTES_W-1:0] sep_bytes    = SPACE_SEP;
	logic [SEP_LEN_W-1:0]   sep_len      = 4'd1;
	logic [SEP_BYTES_W-1:0] window       = '0;
	int                     rec_pos      = 0;
	int                     fld_start    = 0;
	int                     fld_count    = 0;
	int                     fld_number   = 0;
	bit                     rec_overflow = 1'b0;

	separator_field_splitter_unit #(
		.MAX_RECORD(REC_LIMIT),
		.MAX_SEPARATOR(SEP_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Advance the record state by one request; return 1 when it closes a field.
	function automatic bit split_byte(input in_item_t req, output field_desc_t desc);
		bit hit;
		int i;
		int age;
		desc = '0;
		if (req.command == CMD_END) begin
			// End of record: emit the final field (possibly empty), or a reject if the
			// record overran the bound, then start the next record from scratch.
			desc.last_field = 1'b1;
			if (rec_overflow) begin
				desc.record_too_long = 1'b1;
			end else begin
				desc.field_index  = fld_number[FIELD_W-1:0];
				desc.field_offset = fld_start[FIELD_W-1:0];
				desc.field_length = fld_count[FIELD_W-1:0];
			end
			window       = '0;
			rec_pos      = 0;
			fld_start    = 0;
			fld_count    = 0;
			fld_number   = 0;
			rec_overflow = 1'b0;
			return 1'b1;
		end
		// Drop bytes past the record bound and remember the overrun.
		if (rec_pos >= REC_LIMIT) begin
			rec_overflow = 1'b1;
			return 1'b0;
		end
		window = {window[SEP_BYTES_W-9:0], req.data_byte};
		rec_pos++;
		fld_count++;
		// Match only when the whole separator lies inside the current field; that keeps
		// matches leftmost and non-overlapping.
		hit = (fld_count >= int'(sep_len));
		for (i = 0; i < int'(sep_len); i++) begin
			age = int'(sep_len) - 1 - i;
			if (window[8*age +: 8] != sep_bytes[8*i +: 8])
				hit = 1'b0;
		end
		if (!hit)
			return 1'b0;
		desc.field_index  = fld_number[FIELD_W-1:0];
		desc.field_offset = fld_start[FIELD_W-1:0];
		desc.field_length = FIELD_W'(fld_count - int'(sep_len));
		fld_number++;
		fld_start = rec_pos;
		fld_count = 0;
		return 1'b1;
	endfunction

	task automatic report_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [FIELD_W-1:0] got,
			input logic [FIELD_W-1:0] want);
		if (got !== want)
			report_error($sformatf("%s expected %0d, got %0d", name, want, got));
	endtask

	task automatic push_byte(input logic [7:0] b);
		in_item_t req;
		req.command   = CMD_BYTE;
		req.data_byte = b;
		byte_requests.push_back(req);
		queued_items++;
	endtask

	// The byte of an end-of-record request is ignored, so make it random.
	task automatic push_end();
		in_item_t req;
		req.command   = CMD_END;
		req.data_byte = 8'($urandom);
		byte_requests.push_back(req);
		queued_items++;
	endtask

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_sep(input int count);
		int k;
		for (k = 0; k < count; k++)
			push_byte(sep_bytes[8*k +: 8]);
	endtask

	// Bias content toward separator bytes so near misses and accidental matches show up.
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 2) == 0)
			return sep_bytes[8*$urandom_range(0, int'(sep_len) - 1) +: 8];
		return 8'($urandom);
	endfunction

	// Hold until the driver is empty and every descriptor is back, then allow for
	// requests still in the pipe that close no field.
	task automatic settle();
		while (byte_requests.size() != 0 || in_valid || descs_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write; call only while the block is idle and at a clock edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEP_BYTES_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_SEP_BYTES) begin
			sep_bytes = val;
		end else if (idx == CFG_SEP_LEN && val[3:0] >= 4'd1 && val[3:0] <= SEP_MAX) begin
			sep_len = val[3:0];
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random records: mostly well-formed field lists, some with a cut-off separator
	// before the end, some plain noise. Sometimes leave a record open at the end so the
	// next separator setting lands mid-record.
	task automatic random_records(input int budget);
		int goal;
		int kind;
		int nf;
		int f;
		int n;
		int k;
		goal = queued_items + budget;
		while (queued_items < goal) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				n = $urandom_range(1, 24);
				for (k = 0; k < n; k++)
					push_byte(8'($urandom));
			end else begin
				nf = $urandom_range(1, 5);
				for (f = 0; f < nf; f++) begin
					n = $urandom_range(0, 8);
					for (k = 0; k < n; k++)
						push_byte(pick_byte());
					if (f < nf - 1)
						push_sep(int'(sep_len));
				end
				if (kind == 1)
					push_sep($urandom_range(0, int'(sep_len) - 1));
			end
			push_end();
		end
		if ($urandom_range(0, 1) == 1) begin
			n = $urandom_range(1, 6);
			for (k = 0; k < n; k++)
				push_byte(pick_byte());
		end
	endtask

	// New separator, then a batch of random records. The length write carries random
	// upper bits, which the block must ignore.
	task automatic run_segment(input logic [SEP_BYTES_W-1:0] bytes, input int len, input int budget);
		logic [SEP_BYTES_W-1:0] len_word;
		len_word      = {$urandom, $urandom};
		len_word[3:0] = 4'(len);
		write_reg(CFG_SEP_BYTES, bytes);
		write_reg(CFG_SEP_LEN, len_word);
		random_records(budget);
		settle();
	endtask

	// Driver: present requests from the queue with random gaps; hold while stalled.
	always @(posedge clk) begin : request_driver
		field_desc_t desc;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (split_byte(in_data, desc))
					descs_due.push_back(desc);
			end
			if (!in_valid || !in_stall) begin
				if (byte_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= byte_requests.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure, and compare each accepted descriptor in order.
	always @(posedge clk) begin : desc_monitor
		field_desc_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			if (out_valid && !out_stall) begin
				if (descs_due.size() == 0) begin
					report_error($sformatf("unexpected descriptor idx %0d start %0d len %0d",
						out_data.field_index, out_data.field_offset, out_data.field_length));
				end else begin
					want = descs_due.pop_front();
					check_field("field_index", out_data.field_index, want.field_index);
					check_field("field_offset", out_data.field_offset, want.field_offset);
					check_field("field_length", out_data.field_length, want.field_length);
					check_field("last_field", FIELD_W'(out_data.last_field),
						FIELD_W'(want.last_field));
					check_field("record_too_long", FIELD_W'(out_data.record_too_long),
						FIELD_W'(want.record_too_long));
				end
			end
		end
	end

	initial begin : stimulus
		int pos;
		logic [7:0] filler;
		logic [7:0] rep;
		int k;

		// First idling mode: sender gaps light, receiver stalls heavy.
		send_idle_pct  = 20;
		recv_stall_pct = 84;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset separator (one space): two fields, an empty record, extreme bytes
		// followed by two separators in a row (empty fields).
		push_text("ab cd");
		push_end();
		push_end();
		push_byte(8'h00);
		push_byte(8'hFF);
		push_text("  ");
		push_end();
		settle();

		// Unknown indexes and out-of-range lengths: the single space must survive.
		write_reg(CFG_SPARE_2, {$urandom, $urandom});
		write_reg(CFG_SPARE_3, {$urandom, $urandom});
		write_reg(CFG_SEP_LEN, 64'd0);
		write_reg(CFG_SEP_LEN, 64'd9);
		write_reg(CFG_SEP_LEN, 64'd15);
		push_text("x y");
		push_end();
		settle();

		// Two-byte separator "ab"; upper bytes are don't-care. Leave the record open.
		write_reg(CFG_SEP_BYTES, {$urandom, 16'($urandom), 16'h6261});
		write_reg(CFG_SEP_LEN, 64'd2);
		push_text("aabxa");
		settle();

		// Change to "ac" mid-record: the 'a' already in the window pairs with the next 'c'.
		// Then end on an unfinished separator, which stays part of the final field.
		write_reg(CFG_SEP_BYTES, {$urandom, 16'($urandom), 16'h6361});
		push_text("cab");
		push_byte("a");
		push_end();
		settle();

		// Random part, first idling mode. Extremes: all-zero and all-one separators.
		run_segment(64'h0, 1, 85);
		run_segment({64{1'b1}}, 8, 85);
		rep = 8'($urandom);
		run_segment({8{rep}}, 2, 85);

		// Second idling mode: sender gaps heavy, receiver stalls light.
		send_idle_pct  = 84;
		recv_stall_pct = 20;
		run_segment({$urandom, $urandom}, 3, 85);
		run_segment({$urandom, $urandom}, 8, 85);
		run_segment({$urandom, $urandom}, 1, 85);

		// No idling on either side.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_segment({$urandom, $urandom}, 4, 85);
		run_segment({$urandom, $urandom}, $urandom_range(5, 7), 40);

		// Overlong record: sparse separators, one ending exactly at the bound so the
		// following field starts at the bound, then bytes and a separator that get dropped.
		pos = 0;
		while (pos < REC_LIMIT - int'(sep_len)) begin
			if (pos % 97 == 50 && pos + 2 * int'(sep_len) <= REC_LIMIT) begin
				push_sep(int'(sep_len));
				pos += int'(sep_len);
			end else begin
				filler = 8'($urandom);
				if (filler == sep_bytes[7:0])
					filler = ~filler;
				push_byte(filler);
				pos++;
			end
		end
		push_sep(int'(sep_len));
		for (k = 0; k < 6; k++)
			push_byte(pick_byte());
		push_sep(int'(sep_len));
		push_end();
		// A short record after the reject must start from clean state.
		random_records(30);
		push_end();
		settle();

		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin : watchdog
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### separator_field_splitter_unit.f
+incdir+rtl
rtl/sfs_pkg.sv
rtl/sfs_match.sv
rtl/sfs_track.sv
rtl/separator_field_splitter_unit.sv
sim/tb.sv
